// ===== rtl/kt_pkg.sv =====
// Shared types and constants for the key table with lazy delete.
package kt_pkg;

   localparam int MODE_W   = 3;
   localparam int KEY_W    = 31;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int FILL_W   = 5;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND    = 3'd4;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  entry_key;
      logic [VAL_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    found_value;
      logic [FIDX_W-1:0]   found_index;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

   // one table row as held in the memory
   typedef struct packed {
      logic             deleted;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/kt_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
module kt_mem #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  kt_pkg::entry_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output kt_pkg::entry_type        rd_data
);
   import kt_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/key_table_with_lazy_delete_top.sv =====
// Top level of the append-only key table with tombstone delete and compaction.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+-------------------------------------------
//  request  | start, busy, req_data        | beat taken at edge with start=1, busy=0
//  response | rsp_strobe, rsp_data         | one-cycle strobe, receiver cannot stall
//
// Every operation walks the stored rows once through the entry memory, one read
// a cycle; the single memory read port sets this rate.
// The response beat shows up in the first cycle with busy low; a new request can
// be taken in that same cycle.
// Reset (synchronous) empties the table by clearing the fill count; rows
// above the fill count are never read, so the memory itself is not cleared.
// No stalls: the response is presented once and never held.
module key_table_with_lazy_delete_top #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  kt_pkg::req_type req_data,
   output logic            rsp_strobe,
   output kt_pkg::rsp_type rsp_data
);
   import kt_pkg::*;

   localparam int IW = $clog2(DEPTH);       // row address width
   localparam int CW = $clog2(DEPTH + 1);   // fill count width, holds DEPTH itself

   // control state
   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;          // rows in use
   logic           dv_ff, dv_in;            // read data valid this cycle
   logic           strobe_ff, strobe_in;

   // per-item working registers
   req_type        op_ff, op_in;
   logic [CW-1:0]  rptr_ff, rptr_in;        // next row to read
   logic [IW-1:0]  didx_ff, didx_in;        // row whose data is on rd_data
   logic [CW-1:0]  wptr_ff, wptr_in;        // compaction write row
   logic           dup_ff, dup_in;          // key seen, live or deleted
   logic           hit_ff, hit_in;          // first qualifying row found
   logic [IW-1:0]  hidx_ff, hidx_in;
   logic [VAL_W-1:0] hval_ff, hval_in;
   rsp_type        rsp_ff, rsp_in;

   // memory port
   logic           mem_rd_en;
   logic [IW-1:0]  mem_rd_addr;
   entry_type      mem_rd_data;
   logic           mem_wr_en;
   logic [IW-1:0]  mem_wr_addr;
   entry_type      mem_wr_data;

   logic           key_eq;
   logic           live_eq;
   logic           val_eq;
   logic           row_hit;

   kt_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign key_eq  = (mem_rd_data.key == op_ff.entry_key);
   assign live_eq = key_eq && !mem_rd_data.deleted;
   assign val_eq  = (mem_rd_data.value == op_ff.entry_value);
   // find-by-value ignores the deleted mark; lookup and delete do not
   assign row_hit = (op_ff.mode == MODE_FIND) ? val_eq : live_eq;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dv_in     = dv_ff;
      strobe_in = 1'b0;
      op_in     = op_ff;
      rptr_in   = rptr_ff;
      didx_in   = didx_ff;
      wptr_in   = wptr_ff;
      dup_in    = dup_ff;
      hit_in    = hit_ff;
      hidx_in   = hidx_ff;
      hval_in   = hval_ff;
      rsp_in    = rsp_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = rptr_ff[IW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data;
               rptr_in  = '0;
               wptr_in  = '0;
               dv_in    = 1'b0;
               dup_in   = 1'b0;
               hit_in   = 1'b0;
               hidx_in  = '0;
               hval_in  = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue side: one row per cycle
            if (rptr_ff < cnt_ff) begin
               mem_rd_en = 1'b1;
               didx_in   = rptr_ff[IW-1:0];
               rptr_in   = rptr_ff + 1'b1;
               dv_in     = 1'b1;
            end else begin
               dv_in    = 1'b0;
               state_in = ST_FIN;   // last row, if any, is evaluated this cycle
            end

            // evaluate side: data of the row read last cycle
            if (dv_ff) begin
               if (key_eq) begin
                  dup_in = 1'b1;
               end
               if (row_hit && !hit_ff) begin
                  hit_in  = 1'b1;
                  hidx_in = didx_ff;
                  hval_in = mem_rd_data.value;
               end
               // compaction: live rows slide down; write row never passes read row
               if (op_ff.mode == MODE_COMPACT && !mem_rd_data.deleted) begin
                  mem_wr_en           = 1'b1;
                  mem_wr_addr         = wptr_ff[IW-1:0];
                  mem_wr_data.deleted = 1'b0;
                  mem_wr_data.key     = mem_rd_data.key;
                  mem_wr_data.value   = mem_rd_data.value;
                  wptr_in             = wptr_ff + 1'b1;
               end
            end
         end

         ST_FIN: begin
            rsp_in.status      = STATUS_OK;
            rsp_in.found_value = '0;
            rsp_in.found_index = '0;
            case (op_ff.mode)
               MODE_INSERT: begin
                  if (dup_ff) begin
                     rsp_in.status = STATUS_DUP;
                  end else if (cnt_ff == CW'(DEPTH)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     mem_wr_en           = 1'b1;
                     mem_wr_addr         = cnt_ff[IW-1:0];
                     mem_wr_data.deleted = 1'b0;
                     mem_wr_data.key     = op_ff.entry_key;
                     mem_wr_data.value   = op_ff.entry_value;
                     cnt_in              = cnt_ff + 1'b1;
                  end
               end
               MODE_LOOKUP: begin
                  if (hit_ff) begin
                     rsp_in.found_value = hval_ff;
                  end else begin
                     rsp_in.status = STATUS_MISS;
                  end
               end
               MODE_DELETE: begin
                  if (hit_ff) begin
                     // tombstone: rewrite the row with the mark set
                     mem_wr_en           = 1'b1;
                     mem_wr_addr         = hidx_ff;
                     mem_wr_data.deleted = 1'b1;
                     mem_wr_data.key     = op_ff.entry_key;
                     mem_wr_data.value   = hval_ff;
                  end else begin
                     rsp_in.status = STATUS_MISS;
                  end
               end
               MODE_COMPACT: begin
                  cnt_in = wptr_ff;
               end
               MODE_FIND: begin
                  if (hit_ff) begin
                     rsp_in.found_index = FIDX_W'(hidx_ff);
                  end else begin
                     rsp_in.status = STATUS_MISS;
                  end
               end
               default: begin
                  // unused codes: report ok, touch nothing
               end
            endcase
            rsp_in.fill_count = FILL_W'(cnt_in);
            strobe_in         = 1'b1;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         dv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         dv_ff     <= dv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rptr_ff <= rptr_in;
      didx_ff <= didx_in;
      wptr_ff <= wptr_in;
      dup_ff  <= dup_in;
      hit_ff  <= hit_in;
      hidx_ff <= hidx_in;
      hval_ff <= hval_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // the fill count never runs past the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("fill count above table size");

   // every finished item gives exactly one response beat, the cycle after
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> rsp_strobe)
      else $error("missing response beat");

   a_rsp_only_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_FIN))
      else $error("response beat without a finished item");

   // the read pointer stays within the rows in use during a scan
   a_rptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rptr_ff <= cnt_ff))
      else $error("read pointer past fill count");

   // compaction writes never overtake the row being evaluated
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mem_wr_en) |-> (wptr_ff[IW-1:0] <= didx_ff))
      else $error("compaction write ahead of read");

endmodule
